FILE: rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types and constants for the set-1 scancode decoder with entry ring.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int RING_DEPTH = 256;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int ENTRY_W    = 9;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    localparam int OQ_DEPTH   = 4;
    localparam int OQ_AW      = $clog2(OQ_DEPTH);
    localparam int OQ_CW      = $clog2(OQ_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_SCAN = 2'd0,
        OP_CHAR = 2'd1,
        OP_POP  = 2'd2,
        OP_IDLE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CMD_NOP  = 2'd0,
        CMD_PUSH = 2'd1,
        CMD_POP  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [ENTRY_W-1:0] entry;
    } t_cmd;

    typedef struct packed {
        logic       pop_ok;
        logic       is_special;
        logic [7:0] code;
    } t_result;

    // scancodes
    localparam logic [7:0] SC_PREFIX     = 8'hE0;
    localparam logic [7:0] SC_LSHIFT_MK  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MK  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
    localparam logic [7:0] SC_CTRL_MK    = 8'h1D;
    localparam logic [7:0] SC_CTRL_BRK   = 8'h9D;
    localparam logic [7:0] SC_UP         = 8'h48;
    localparam logic [7:0] SC_DOWN       = 8'h50;
    localparam logic [7:0] SC_LEFT       = 8'h4B;
    localparam logic [7:0] SC_RIGHT      = 8'h4D;
    localparam logic [7:0] SC_DELETE     = 8'h53;
    localparam logic [7:0] SC_HOME       = 8'h47;
    localparam logic [7:0] SC_END        = 8'h4F;
    localparam logic [7:0] SC_PGUP       = 8'h49;
    localparam logic [7:0] SC_PGDN       = 8'h51;
    localparam logic [7:0] SC_INSERT     = 8'h52;

    // special key indexes
    localparam logic [7:0] SP_UP        = 8'd0;
    localparam logic [7:0] SP_DOWN      = 8'd1;
    localparam logic [7:0] SP_LEFT      = 8'd2;
    localparam logic [7:0] SP_RIGHT     = 8'd3;
    localparam logic [7:0] SP_DELETE    = 8'd4;
    localparam logic [7:0] SP_HOME      = 8'd5;
    localparam logic [7:0] SP_END       = 8'd6;
    localparam logic [7:0] SP_PGUP      = 8'd7;
    localparam logic [7:0] SP_PGDN      = 8'd8;
    localparam logic [7:0] SP_INSERT    = 8'd9;
    localparam logic [7:0] SP_CTRL_HOME = 8'd10;
    localparam logic [7:0] SP_CTRL_END  = 8'd11;

endpackage

FILE: rtl/scancode_set1_decoder_fifo.sv
// Items go from the command queue through a stage-two register to the result queue.
// One item per cycle, set by the single ring issue, while the result queue has room.
// Items queue in a four-deep command queue, results in a four-deep result queue.
// Reset (i_rst_n low at a clock edge) clears pointers, shift/ctrl/E0 state and
// both queues; ring contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// scancode_set1_decoder_fifo
// Set-1 scancode decoder feeding a ring of ASCII and special-key entries.
// ----------------------------------------------------------------------------
module scancode_set1_decoder_fifo
    import ssd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_op,
    input  logic [7:0] i_scancode,
    input  logic [7:0] i_char_in,
    output logic       empty,
    input  logic       pop,
    output logic       o_pop_ok,
    output logic       o_is_special,
    output logic [7:0] o_code
);

    t_cmd w_front_cmd;
    t_cmd w_q_cmd;
    logic w_accept;
    logic w_q_valid;
    logic w_q_pop;

    assign w_accept = push && !full;

    ssd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_op       (i_op),
        .i_scancode (i_scancode),
        .i_char_in  (i_char_in),
        .o_cmd      (w_front_cmd)
    );

    ssd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_cmd   (w_front_cmd),
        .o_full  (full),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_cmd   (w_q_cmd)
    );

    ssd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_q_valid),
        .i_cmd        (w_q_cmd),
        .o_cmd_pop    (w_q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_pop_ok     (o_pop_ok),
        .o_is_special (o_is_special),
        .o_code       (o_code)
    );

endmodule

FILE: rtl/ssd_front.sv
// ----------------------------------------------------------------------------
// ssd_front
// Classifies each item into a ring command and tracks shift, ctrl and E0.
// ----------------------------------------------------------------------------
module ssd_front
    import ssd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [1:0] i_op,
    input  logic [7:0] i_scancode,
    input  logic [7:0] i_char_in,
    output t_cmd       o_cmd
);

    localparam int         MAP_LEN    = 59;
    localparam logic [7:0] MAP_LEN_B  = 8'(MAP_LEN);
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7A;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_Z    = 8'h5A;
    localparam logic [7:0] LOWER_BASE = 8'h60;
    localparam logic [7:0] UPPER_BASE = 8'h40;

    localparam logic [7:0] MAP_PLAIN [0:MAP_LEN-1] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
    };

    localparam logic [7:0] MAP_SHIFT [0:MAP_LEN-1] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
    };

    logic       r_shift, n_shift;
    logic       r_ctrl, n_ctrl;
    logic       r_prefix, n_prefix;
    logic [7:0] w_char;
    logic [5:0] w_idx;

    assign w_idx  = i_scancode[5:0];
    assign w_char = r_shift ? MAP_SHIFT[w_idx] : MAP_PLAIN[w_idx];

    always_comb begin
        n_shift  = r_shift;
        n_ctrl   = r_ctrl;
        n_prefix = r_prefix;
        o_cmd    = '{kind: CMD_NOP, entry: '0};
        case (t_op'(i_op))
            OP_CHAR: begin
                o_cmd = '{kind: CMD_PUSH, entry: {1'b0, i_char_in}};
            end
            OP_POP: begin
                o_cmd.kind = CMD_POP;
            end
            OP_SCAN: begin
                if (i_scancode == SC_PREFIX) begin
                    n_prefix = 1'b1;
                end else if (r_prefix) begin
                    n_prefix = 1'b0;
                    case (i_scancode)
                        SC_UP:     o_cmd = '{kind: CMD_PUSH, entry: {1'b1, SP_UP}};
                        SC_DOWN:   o_cmd = '{kind: CMD_PUSH, entry: {1'b1, SP_DOWN}};
                        SC_LEFT:   o_cmd = '{kind: CMD_PUSH, entry: {1'b1, SP_LEFT}};
                        SC_RIGHT:  o_cmd = '{kind: CMD_PUSH, entry: {1'b1, SP_RIGHT}};
                        SC_DELETE: o_cmd = '{kind: CMD_PUSH, entry: {1'b1, SP_DELETE}};
                        SC_HOME:   o_cmd = '{kind: CMD_PUSH,
                                             entry: {1'b1, r_ctrl ? SP_CTRL_HOME : SP_HOME}};
                        SC_END:    o_cmd = '{kind: CMD_PUSH,
                                             entry: {1'b1, r_ctrl ? SP_CTRL_END : SP_END}};
                        SC_PGUP:   o_cmd = '{kind: CMD_PUSH, entry: {1'b1, SP_PGUP}};
                        SC_PGDN:   o_cmd = '{kind: CMD_PUSH, entry: {1'b1, SP_PGDN}};
                        SC_INSERT: o_cmd = '{kind: CMD_PUSH, entry: {1'b1, SP_INSERT}};
                        SC_CTRL_MK:  n_ctrl = 1'b1;
                        SC_CTRL_BRK: n_ctrl = 1'b0;
                        default: ;
                    endcase
                end else if (i_scancode == SC_LSHIFT_MK || i_scancode == SC_RSHIFT_MK) begin
                    n_shift = 1'b1;
                end else if (i_scancode == SC_LSHIFT_BRK || i_scancode == SC_RSHIFT_BRK) begin
                    n_shift = 1'b0;
                end else if (i_scancode == SC_CTRL_MK) begin
                    n_ctrl = 1'b1;
                end else if (i_scancode == SC_CTRL_BRK) begin
                    n_ctrl = 1'b0;
                end else if (!i_scancode[7] && i_scancode < MAP_LEN_B && w_char != 8'h00) begin
                    // with ctrl held only letters survive, as control codes
                    if (!r_ctrl) begin
                        o_cmd = '{kind: CMD_PUSH, entry: {1'b0, w_char}};
                    end else if (w_char >= LOWER_A && w_char <= LOWER_Z) begin
                        o_cmd = '{kind: CMD_PUSH, entry: {1'b0, w_char - LOWER_BASE}};
                    end else if (w_char >= UPPER_A && w_char <= UPPER_Z) begin
                        o_cmd = '{kind: CMD_PUSH, entry: {1'b0, w_char - UPPER_BASE}};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= 1'b0;
            r_ctrl   <= 1'b0;
            r_prefix <= 1'b0;
        end else if (i_accept) begin
            r_shift  <= n_shift;
            r_ctrl   <= n_ctrl;
            r_prefix <= n_prefix;
        end
    end

endmodule

FILE: rtl/ssd_cmdq.sv
// ----------------------------------------------------------------------------
// ssd_cmdq
// Short command queue between the classifier and the ring back end.
// ----------------------------------------------------------------------------
module ssd_cmdq
    import ssd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd               r_slot [0:CMDQ_DEPTH-1];
    logic [CMDQ_AW-1:0] r_wr, r_rd;
    logic [CMDQ_CW-1:0] r_count;
    logic               w_push, w_pop;

    assign o_full  = (r_count == CMDQ_CW'(CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/ssd_back.sv
// ----------------------------------------------------------------------------
// ssd_back
// Executes ring commands on the entry memory and queues one result per item.
// ----------------------------------------------------------------------------
module ssd_back
    import ssd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    output logic       o_empty,
    input  logic       i_pop,
    output logic       o_pop_ok,
    output logic       o_is_special,
    output logic [7:0] o_code
);

    logic [ENTRY_W-1:0] r_ring [0:RING_DEPTH-1];
    logic [RING_AW-1:0] r_wr, r_rd;
    logic [RING_AW-1:0] w_wr_next, w_rd_next;
    logic               w_ring_empty, w_ring_full;
    logic               w_issue, w_we, w_re;

    logic               r_s2_valid;
    logic               r_s2_hit;
    logic [ENTRY_W-1:0] r_rd_data;

    t_result            r_oq [0:OQ_DEPTH-1];
    logic [OQ_AW-1:0]   r_oq_wr, r_oq_rd;
    logic [OQ_CW-1:0]   r_oq_count;
    logic [OQ_CW:0]     w_oq_claim;
    logic               w_oq_pop;
    t_result            w_s2_res;
    t_result            w_head;

    assign w_wr_next    = (r_wr == RING_AW'(RING_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign w_rd_next    = (r_rd == RING_AW'(RING_DEPTH - 1)) ? '0 : r_rd + 1'b1;
    assign w_ring_empty = (r_rd == r_wr);
    assign w_ring_full  = (w_wr_next == r_rd);

    // issue only when the result queue has a slot for this item
    assign w_oq_claim = {1'b0, r_oq_count} + {{OQ_CW{1'b0}}, r_s2_valid};
    assign w_issue    = i_cmd_valid && (w_oq_claim < (OQ_CW + 1)'(OQ_DEPTH));
    assign o_cmd_pop  = w_issue;

    assign w_we = w_issue && (i_cmd.kind == CMD_PUSH) && !w_ring_full;
    assign w_re = w_issue && (i_cmd.kind == CMD_POP) && !w_ring_empty;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_ring[r_wr] <= i_cmd.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rd_data <= r_ring[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr       <= '0;
            r_rd       <= '0;
            r_s2_valid <= 1'b0;
            r_s2_hit   <= 1'b0;
        end else begin
            if (w_we) begin
                r_wr <= w_wr_next;
            end
            if (w_re) begin
                r_rd <= w_rd_next;
            end
            r_s2_valid <= w_issue;
            r_s2_hit   <= w_re;
        end
    end

    always_comb begin
        w_s2_res = '0;
        if (r_s2_hit) begin
            w_s2_res = '{pop_ok: 1'b1, is_special: r_rd_data[ENTRY_W-1],
                         code: r_rd_data[7:0]};
        end
    end

    assign w_head       = r_oq[r_oq_rd];
    assign o_empty      = (r_oq_count == '0);
    assign o_pop_ok     = w_head.pop_ok;
    assign o_is_special = w_head.is_special;
    assign o_code       = w_head.code;
    assign w_oq_pop     = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_oq[r_oq_wr] <= w_s2_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr    <= '0;
            r_oq_rd    <= '0;
            r_oq_count <= '0;
        end else begin
            if (r_s2_valid) begin
                r_oq_wr <= (r_oq_wr == OQ_AW'(OQ_DEPTH - 1)) ? '0 : r_oq_wr + 1'b1;
            end
            if (w_oq_pop) begin
                r_oq_rd <= (r_oq_rd == OQ_AW'(OQ_DEPTH - 1)) ? '0 : r_oq_rd + 1'b1;
            end
            if (r_s2_valid && !w_oq_pop) begin
                r_oq_count <= r_oq_count + 1'b1;
            end else if (w_oq_pop && !r_s2_valid) begin
                r_oq_count <= r_oq_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/ssd_checker.sv
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks on the scancode decoder results.
// ----------------------------------------------------------------------------
module ssd_checker
    import ssd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic       o_pop_ok,
    input logic       o_is_special,
    input logic [7:0] o_code
);

    // nothing is waiting right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> empty)
        else $error("result waiting right after reset");

    // results of non-pop items and empty pops are all zero
    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_pop_ok) |-> (!o_is_special && o_code == 8'd0))
        else $error("non-pop result carries data");

    // special entries only come from a successful pop, with a known index
    a_special_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_is_special) |-> (o_pop_ok && o_code <= SP_CTRL_END))
        else $error("special entry out of range");

    // a waiting result holds until taken
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_pop_ok) && $stable(o_is_special)
                              && $stable(o_code)))
        else $error("waiting result changed");

endmodule

bind scancode_set1_decoder_fifo ssd_checker u_ssd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pop          (pop),
    .o_pop_ok     (o_pop_ok),
    .o_is_special (o_is_special),
    .o_code       (o_code)
);

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the set-1 scancode decoder: a directed table of key sequences, then
// random keystrokes, character pushes and pops under varying idle and stall
// pressure; results compared against the table or a cycle-free decode model.
// ----------------------------------------------------------------------------
module testbench;
    import ssd_pkg::*;

    localparam int KEYMAP_LEN     = 59;
    localparam int HOLD_CYCLES    = 400;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam t_result NONE      = '0;

    typedef struct {
        t_op        op;
        logic [7:0] sc;
        logic [7:0] ch;
        bit         fixed;
        t_result    res;
    } t_key_item;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       push         = 1'b0;
    logic [1:0] i_op         = OP_IDLE;
    logic [7:0] i_scancode   = 8'h00;
    logic [7:0] i_char_in    = 8'h00;
    logic       pop          = 1'b0;
    logic       full;
    logic       empty;
    logic       o_pop_ok;
    logic       o_is_special;
    logic [7:0] o_code;

    scancode_set1_decoder_fifo DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_op         (i_op),
        .i_scancode   (i_scancode),
        .i_char_in    (i_char_in),
        .empty        (empty),
        .pop          (pop),
        .o_pop_ok     (o_pop_ok),
        .o_is_special (o_is_special),
        .o_code       (o_code)
    );

    always #2 i_clk = ~i_clk;

    // US layout, unshifted and shifted, indexed by make code
    logic [7:0] key_plain [KEYMAP_LEN] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
    };
    logic [7:0] key_shift [KEYMAP_LEN] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
    };
    logic [7:0] nav_codes [10] = '{
        SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT, SC_DELETE,
        SC_HOME, SC_END, SC_PGUP, SC_PGDN, SC_INSERT
    };

    // directed key sequences; scancode and push items always give the
    // all-zero result, pops of decoded keys go through the model
    t_key_item directed_rows [26] = '{
        '{OP_POP,  8'h00, 8'h00, 1'b1, NONE},
        '{OP_IDLE, 8'hFF, 8'hFF, 1'b1, NONE},
        '{OP_CHAR, 8'hFF, 8'h00, 1'b1, NONE},
        '{OP_CHAR, 8'h00, 8'hFF, 1'b1, NONE},
        '{OP_POP,  8'h00, 8'h00, 1'b1, '{1'b1, 1'b0, 8'h00}},
        '{OP_POP,  8'h00, 8'h00, 1'b1, '{1'b1, 1'b0, 8'hFF}},
        '{OP_SCAN, 8'h1E, 8'h00, 1'b1, NONE},
        '{OP_SCAN, SC_LSHIFT_MK, 8'h00, 1'b1, NONE},
        '{OP_SCAN, 8'h1E, 8'h00, 1'b1, NONE},
        '{OP_SCAN, SC_LSHIFT_BRK, 8'h00, 1'b1, NONE},
        '{OP_SCAN, SC_CTRL_MK, 8'h00, 1'b1, NONE},
        '{OP_SCAN, 8'h2E, 8'h00, 1'b1, NONE},
        '{OP_SCAN, 8'h02, 8'h00, 1'b1, NONE},
        '{OP_SCAN, SC_PREFIX, 8'h00, 1'b1, NONE},
        '{OP_SCAN, SC_PREFIX, 8'h00, 1'b1, NONE},
        '{OP_SCAN, SC_HOME, 8'h00, 1'b1, NONE},
        '{OP_SCAN, SC_PREFIX, 8'h00, 1'b1, NONE},
        '{OP_SCAN, SC_CTRL_BRK, 8'h00, 1'b1, NONE},
        '{OP_SCAN, SC_PREFIX, 8'h00, 1'b1, NONE},
        '{OP_SCAN, 8'h5C, 8'h00, 1'b1, NONE},
        '{OP_SCAN, 8'h9E, 8'h00, 1'b1, NONE},
        '{OP_POP,  8'h00, 8'h00, 1'b0, NONE},
        '{OP_POP,  8'h00, 8'h00, 1'b0, NONE},
        '{OP_POP,  8'h00, 8'h00, 1'b0, NONE},
        '{OP_POP,  8'h00, 8'h00, 1'b0, NONE},
        '{OP_POP,  8'h00, 8'h00, 1'b1, NONE}
    };

    // decode model state
    logic [ENTRY_W-1:0] ring_entries [RING_DEPTH];
    logic [RING_AW-1:0] ring_wr    = '0;
    logic [RING_AW-1:0] ring_rd    = '0;
    logic               shift_down = 1'b0;
    logic               ctrl_down  = 1'b0;
    logic               e0_pending = 1'b0;

    t_key_item key_items [$];
    t_result   pending_results [$];
    t_key_item cur_item;
    t_result   want;
    t_result   exp_res;
    int        tx_idle_pct  = 0;
    int        rx_stall_pct = 0;
    int        hold_seq     = 0;
    int        hold_seen    = 0;
    int        hold_left    = 0;
    int        mismatch_cnt = 0;
    int        result_cnt   = 0;
    int        cycle_cnt    = 0;

    function automatic void ring_put(logic [ENTRY_W-1:0] entry);
        logic [RING_AW-1:0] nxt;
        nxt = ring_wr + 1'b1;
        // drop the entry when the ring already holds depth minus one
        if (nxt != ring_rd) begin
            ring_entries[ring_wr] = entry;
            ring_wr = nxt;
        end
    endfunction

    function automatic t_result decode_item(t_key_item it);
        t_result    res;
        logic [7:0] ch;
        res = '0;
        case (it.op)
            OP_SCAN: begin
                if (it.sc == SC_PREFIX) begin
                    e0_pending = 1'b1;
                end else if (e0_pending) begin
                    e0_pending = 1'b0;
                    case (it.sc)
                        SC_UP:       ring_put({1'b1, SP_UP});
                        SC_DOWN:     ring_put({1'b1, SP_DOWN});
                        SC_LEFT:     ring_put({1'b1, SP_LEFT});
                        SC_RIGHT:    ring_put({1'b1, SP_RIGHT});
                        SC_DELETE:   ring_put({1'b1, SP_DELETE});
                        SC_HOME:     ring_put({1'b1, ctrl_down ? SP_CTRL_HOME : SP_HOME});
                        SC_END:      ring_put({1'b1, ctrl_down ? SP_CTRL_END : SP_END});
                        SC_PGUP:     ring_put({1'b1, SP_PGUP});
                        SC_PGDN:     ring_put({1'b1, SP_PGDN});
                        SC_INSERT:   ring_put({1'b1, SP_INSERT});
                        SC_CTRL_MK:  ctrl_down = 1'b1;
                        SC_CTRL_BRK: ctrl_down = 1'b0;
                        default: ;
                    endcase
                end else if (it.sc == SC_LSHIFT_MK || it.sc == SC_RSHIFT_MK) begin
                    shift_down = 1'b1;
                end else if (it.sc == SC_LSHIFT_BRK || it.sc == SC_RSHIFT_BRK) begin
                    shift_down = 1'b0;
                end else if (it.sc == SC_CTRL_MK) begin
                    ctrl_down = 1'b1;
                end else if (it.sc == SC_CTRL_BRK) begin
                    ctrl_down = 1'b0;
                end else if (it.sc < KEYMAP_LEN) begin
                    ch = shift_down ? key_shift[it.sc] : key_plain[it.sc];
                    if (ch != 8'h00) begin
                        // with ctrl held keep only letters, as control codes
                        if (!ctrl_down)
                            ring_put({1'b0, ch});
                        else if (ch >= "a" && ch <= "z")
                            ring_put({1'b0, ch - 8'h60});
                        else if (ch >= "A" && ch <= "Z")
                            ring_put({1'b0, ch - 8'h40});
                    end
                end
            end
            OP_CHAR: ring_put({1'b0, it.ch});
            OP_POP: begin
                if (ring_rd != ring_wr) begin
                    res.pop_ok     = 1'b1;
                    res.is_special = ring_entries[ring_rd][8];
                    res.code       = ring_entries[ring_rd][7:0];
                    ring_rd        = ring_rd + 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic queue_random_keys(input int count);
        int        k;
        t_key_item it;
        repeat (count) begin
            k        = $urandom_range(0, 99);
            it.fixed = 1'b0;
            it.res   = NONE;
            it.op    = OP_SCAN;
            it.sc    = 8'($urandom);
            it.ch    = 8'($urandom);
            if (k < 28) begin
                it.sc = 8'($urandom_range(0, KEYMAP_LEN - 1));
            end else if (k < 34) begin
                case ($urandom_range(0, 3))
                    0: it.sc = SC_LSHIFT_MK;
                    1: it.sc = SC_RSHIFT_MK;
                    2: it.sc = SC_LSHIFT_BRK;
                    default: it.sc = SC_RSHIFT_BRK;
                endcase
            end else if (k < 38) begin
                it.sc = $urandom_range(0, 1) ? SC_CTRL_MK : SC_CTRL_BRK;
            end else if (k < 50) begin
                it.sc = SC_PREFIX;
                key_items.push_back(it);
                k = $urandom_range(0, 13);
                if (k < 10)
                    it.sc = nav_codes[k];
                else if (k == 10)
                    it.sc = SC_CTRL_MK;
                else if (k == 11)
                    it.sc = SC_CTRL_BRK;
                else if (k == 12)
                    it.sc = SC_PREFIX;
                else
                    it.sc = 8'($urandom);
            end else if (k < 55) begin
                it.sc = 8'($urandom);
            end else if (k < 63) begin
                it.op = OP_CHAR;
            end else if (k < 65) begin
                it.op = OP_IDLE;
            end else begin
                it.op = OP_POP;
            end
            key_items.push_back(it);
        end
    endtask

    task automatic wait_drained();
        while (key_items.size() != 0 || push || pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (mismatch_cnt < 50)
            $display("mismatch on result %0d: %s got %0h, wanted %0h",
                     result_cnt, what, got, exp_val);
        mismatch_cnt++;
    endtask

    // sender: hold the item until accepted, then advance or idle
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                want = decode_item(cur_item);
                pending_results.push_back(cur_item.fixed ? cur_item.res : want);
            end
            if (!push || !full) begin
                if (key_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    cur_item = key_items.pop_front();
                    push       <= 1'b1;
                    i_op       <= cur_item.op;
                    i_scancode <= cur_item.sc;
                    i_char_in  <= cur_item.ch;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (pop && !empty) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", o_code, 0);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_pop_ok !== exp_res.pop_ok)
                    report_mismatch("pop_ok", o_pop_ok, exp_res.pop_ok);
                if (o_is_special !== exp_res.is_special)
                    report_mismatch("is_special", o_is_special, exp_res.is_special);
                if (o_code !== exp_res.code)
                    report_mismatch("code", o_code, exp_res.code);
            end
            result_cnt++;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == TIMEOUT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            key_items.push_back(directed_rows[i]);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 82; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 82; end
                default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
            endcase
            queue_random_keys(290);
            wait_drained();
        end

        // overfill the ring behind a long receiver hold, then drain past empty
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_seq++;
        repeat (280)
            key_items.push_back('{OP_CHAR, 8'($urandom), 8'($urandom), 1'b0, NONE});
        repeat (260)
            key_items.push_back('{OP_POP, 8'($urandom), 8'($urandom), 1'b0, NONE});
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ssd_pkg.sv
rtl/ssd_front.sv
rtl/ssd_cmdq.sv
rtl/ssd_back.sv
rtl/scancode_set1_decoder_fifo.sv
rtl/ssd_checker.sv
sim/testbench.sv
